// ===== design/i2crm_pkg.sv =====
// Package for the I2C register master: request kinds, bus phases, queue item
// and result types, and the sizing constants of the write buffer.
// No dependencies; every other design file but i2crm_ram imports it.
package i2crm_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  localparam logic [7:0] ADDR_RESET = 8'ha2;
  localparam logic [7:0] LOW_RESET = 8'd13;
  localparam logic [7:0] HIGH_RESET = 8'd6;
  localparam logic       READ_BIT = 1'b1;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_PUSH  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_TARGET = 2'd0,
    CFG_LOW    = 2'd1,
    CFG_HIGH   = 2'd2
  } cfg_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_START   = 3'd1,
    PH_RSTART  = 3'd2,
    PH_SEND    = 3'd3,
    PH_ACKCHK  = 3'd4,
    PH_READ    = 3'd5,
    PH_SENDACK = 3'd6,
    PH_STOP    = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    ST_ADDR_W = 2'd0,
    ST_REG    = 2'd1,
    ST_ADDR_R = 2'd2,
    ST_DATA   = 2'd3
  } stage_e;

  typedef struct packed {
    req_e       kind;
    logic       cnt_zero;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] data_byte;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       busy_res;
    logic       done_res;
    logic       acks_ok;
  } result_t;

  typedef struct packed {
    logic  we;
    cfg_e  idx;
    logic [7:0] data;
  } cfg_wr_t;

endpackage

// ===== design/i2crm_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module i2crm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/i2crm_front.sv =====
// Front end: unpacks an incoming stream transaction and classifies it into a
// queue item. Depends on i2crm_pkg.
module i2crm_front (
  input  logic               s_valid_i,
  input  logic [1:0]         s_user_i,
  input  logic [31:0]        s_data_i,
  input  logic               q_full_i,
  output logic               s_ready_o,
  output logic               q_push_o,
  output i2crm_pkg::item_t   q_item_o
);
  import i2crm_pkg::*;

  item_t item;

  always_comb begin
    item.kind       = req_e'(s_user_i);
    item.reg_addr   = s_data_i[7:0];
    item.byte_count = s_data_i[15:8];
    item.data_byte  = s_data_i[23:16];
    item.sda_in     = s_data_i[24];
    item.cnt_zero   = (s_data_i[15:8] == 8'd0) &&
                      ((s_user_i == REQ_READ) || (s_user_i == REQ_WRITE));
  end

  assign s_ready_o = !q_full_i;
  assign q_push_o  = s_valid_i && !q_full_i;
  assign q_item_o  = item;

endmodule

// ===== design/i2crm_queue.sv =====
// Two-entry queue that decouples the front end from the bus engine.
// Depends on i2crm_pkg.
module i2crm_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  i2crm_pkg::item_t item_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output i2crm_pkg::item_t item_o
);
  import i2crm_pkg::*;

  item_t       slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  assign full_o  = count_q[1];
  assign valid_o = (count_q != 2'd0);
  assign item_o  = slot_q[rd_ptr_q];

endmodule

// ===== design/i2crm_back.sv =====
// Bus engine: holds configuration and the bus state machine, executes one
// queued item per cycle while its result register is free or being taken, and
// registers its result. Depends on i2crm_pkg and i2crm_ram.
module i2crm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  i2crm_pkg::cfg_wr_t  cfg_i,
  input  logic                q_valid_i,
  input  i2crm_pkg::item_t    q_item_i,
  output logic                q_pop_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output i2crm_pkg::result_t  m_res_o
);
  import i2crm_pkg::*;

  logic [6:0] target_q;
  logic [7:0] low_q, high_q;

  phase_e     phase_q, phase_d;
  stage_e     stage_q, stage_d;
  logic [1:0] part_q, part_d;
  logic [7:0] tick_q, tick_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] left_q, left_d;
  logic [7:0] regb_q, regb_d;
  logic       is_read_q, is_read_d;
  logic       ack_q, ack_d;
  logic [PTR_W-1:0] push_ptr_q, push_ptr_d;
  logic [PTR_W-1:0] send_ptr_q, send_ptr_d;

  logic       out_valid_q;
  result_t    out_q, res;

  logic       pop;
  logic       ram_we;
  logic [7:0] ram_rdata;
  logic [7:0] len, len_eff;
  logic [8:0] tick_inc;
  logic       last_part;
  logic [7:0] addr_byte;

  assign pop       = q_valid_i && (!out_valid_q || m_ready_i);
  assign ram_we    = pop && (phase_q == PH_IDLE) && (q_item_i.kind == REQ_PUSH);
  assign addr_byte = {target_q, 1'b0};

  i2crm_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_wbuf (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(push_ptr_q),
    .wdata_i(q_item_i.data_byte),
    .raddr_i(send_ptr_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    len       = (part_q == 2'd0) ? low_q : high_q;
    len_eff   = (len == 8'd0) ? 8'd1 : len;
    tick_inc  = {1'b0, tick_q} + 9'd1;
    last_part = ((phase_q == PH_START) || (phase_q == PH_RSTART)) ?
                (part_q == 2'd2) : (part_q == 2'd1);
  end

  always_comb begin
    phase_d    = phase_q;
    stage_d    = stage_q;
    part_d     = part_q;
    tick_d     = tick_q;
    bit_d      = bit_q;
    shift_d    = shift_q;
    left_d     = left_q;
    regb_d     = regb_q;
    is_read_d  = is_read_q;
    ack_d      = ack_q;
    push_ptr_d = push_ptr_q;
    send_ptr_d = send_ptr_q;
    res        = '0;

    case (phase_q)
      PH_IDLE: begin
        res.scl_level = 1'b1;
        res.sda_level = 1'b1;
      end
      PH_START, PH_RSTART: begin
        res.scl_level = (part_q == 2'd0) ? (phase_q == PH_START) : 1'b1;
        res.sda_level = (part_q != 2'd2);
      end
      PH_SEND: begin
        res.scl_level = (part_q != 2'd0);
        res.sda_level = shift_q[~bit_q];
      end
      PH_SENDACK: begin
        res.scl_level = (part_q != 2'd0);
        res.sda_level = (left_q == 8'd0);
      end
      PH_STOP: begin
        res.scl_level = (part_q != 2'd0);
        res.sda_level = 1'b0;
      end
      default: begin
        res.scl_level = (part_q != 2'd0);
        res.sda_level = 1'b1;
      end
    endcase

    if (phase_q == PH_IDLE) begin
      if ((q_item_i.kind == REQ_READ) || (q_item_i.kind == REQ_WRITE)) begin
        if (q_item_i.cnt_zero) begin
          res.done_res = 1'b1;
        end else begin
          is_read_d  = (q_item_i.kind == REQ_READ);
          regb_d     = q_item_i.reg_addr;
          left_d     = q_item_i.byte_count;
          send_ptr_d = '0;
          ack_d      = 1'b1;
          tick_d     = 8'd0;
          part_d     = 2'd0;
          bit_d      = 3'd0;
          phase_d    = PH_START;
        end
      end else if (q_item_i.kind == REQ_PUSH) begin
        push_ptr_d = (push_ptr_q == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : push_ptr_q + 1'b1;
      end
    end else if (q_item_i.kind == REQ_TICK) begin
      tick_d = tick_inc[7:0];
      if (tick_inc >= {1'b0, len_eff}) begin
        tick_d = 8'd0;
        if (!last_part) begin
          part_d = part_q + 2'd1;
        end else begin
          part_d = 2'd0;
          case (phase_q)
            PH_START: begin
              shift_d = addr_byte;
              stage_d = ST_ADDR_W;
              phase_d = PH_SEND;
              bit_d   = 3'd0;
            end
            PH_RSTART: begin
              shift_d = {target_q, READ_BIT};
              stage_d = ST_ADDR_R;
              phase_d = PH_SEND;
              bit_d   = 3'd0;
            end
            PH_SEND: begin
              bit_d = bit_q + 3'd1;
              if (bit_q == 3'd7) begin
                phase_d = PH_ACKCHK;
              end
            end
            PH_ACKCHK: begin
              if (q_item_i.sda_in) begin
                ack_d = 1'b0;
              end
              if (stage_q == ST_ADDR_W) begin
                shift_d = regb_q;
                stage_d = ST_REG;
                phase_d = PH_SEND;
                bit_d   = 3'd0;
              end else if ((stage_q == ST_REG) && is_read_q) begin
                phase_d = PH_RSTART;
              end else if (stage_q == ST_ADDR_R) begin
                phase_d = PH_READ;
                bit_d   = 3'd0;
                shift_d = 8'd0;
              end else if (left_q != 8'd0) begin
                shift_d    = ram_rdata;
                send_ptr_d = (send_ptr_q == PTR_W'(BUFFER_DEPTH - 1)) ?
                             '0 : send_ptr_q + 1'b1;
                left_d     = left_q - 8'd1;
                stage_d    = ST_DATA;
                phase_d    = PH_SEND;
                bit_d      = 3'd0;
              end else begin
                phase_d = PH_STOP;
              end
            end
            PH_READ: begin
              shift_d = {shift_q[6:0], q_item_i.sda_in};
              bit_d   = bit_q + 3'd1;
              if (bit_q == 3'd7) begin
                res.read_valid = 1'b1;
                res.read_byte  = {shift_q[6:0], q_item_i.sda_in};
                left_d         = left_q - 8'd1;
                phase_d        = PH_SENDACK;
              end
            end
            PH_SENDACK: begin
              if (left_q != 8'd0) begin
                phase_d = PH_READ;
                bit_d   = 3'd0;
                shift_d = 8'd0;
              end else begin
                phase_d = PH_STOP;
              end
            end
            PH_STOP: begin
              phase_d      = PH_IDLE;
              res.done_res = 1'b1;
              res.acks_ok  = ack_q;
              if (!is_read_q) begin
                push_ptr_d = '0;
              end
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
        end
      end
    end

    res.busy_res = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= ADDR_RESET[7:1];
      low_q    <= LOW_RESET;
      high_q   <= HIGH_RESET;
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        CFG_TARGET: target_q <= cfg_i.data[6:0];
        CFG_LOW:    low_q    <= cfg_i.data;
        CFG_HIGH:   high_q   <= cfg_i.data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      stage_q    <= ST_ADDR_W;
      part_q     <= 2'd0;
      tick_q     <= 8'd0;
      bit_q      <= 3'd0;
      shift_q    <= 8'd0;
      left_q     <= 8'd0;
      regb_q     <= 8'd0;
      is_read_q  <= 1'b0;
      ack_q      <= 1'b1;
      push_ptr_q <= '0;
      send_ptr_q <= '0;
    end else if (pop) begin
      phase_q    <= phase_d;
      stage_q    <= stage_d;
      part_q     <= part_d;
      tick_q     <= tick_d;
      bit_q      <= bit_d;
      shift_q    <= shift_d;
      left_q     <= left_d;
      regb_q     <= regb_d;
      is_read_q  <= is_read_d;
      ack_q      <= ack_d;
      push_ptr_q <= push_ptr_d;
      send_ptr_q <= send_ptr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= res;
    end
  end

  assign q_pop_o   = pop;
  assign m_valid_o = out_valid_q;
  assign m_res_o   = out_q;

endmodule

// ===== design/i2c_register_master.sv =====
// I2C register master takes one request per clock cycle while the queue is not
// full and returns one result transaction per request, in order. A request is
// written into a two-entry queue and, once the bus engine pops it, its result
// is held in the engine's output register; the engine retires one request per
// cycle and the output register keeps the rate while the downstream side is ready.
// Each tick request advances the bus by one time tick, so the bus speed follows
// the tick rate together with the low and high tick counts. The write buffer
// is a 256-entry memory that is read ahead of use through a registered port.
// Depends on i2crm_pkg, i2crm_front, i2crm_queue and i2crm_back.
module i2c_register_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // reg_addr[7:0], byte_count[15:8], data_byte[23:16], sda_in[24], zero above.
  input  logic [31:0] s_axis_tdata,
  // req_type[1:0].
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scl_level[0], sda_level[1], read_byte[9:2], read_valid[10], busy_res[11],
  // done_res[12], acks_ok[13], zero above.
  output logic [15:0] m_axis_tdata
);
  import i2crm_pkg::*;

  item_t   front_item, q_item;
  logic    q_push, q_full, q_valid, q_pop;
  result_t res;
  cfg_wr_t cfg;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_e'(cfg_idx_i);
  assign cfg.data = cfg_data_i;

  i2crm_front u_front (
    .s_valid_i(s_axis_tvalid),
    .s_user_i (s_axis_tuser),
    .s_data_i (s_axis_tdata),
    .q_full_i (q_full),
    .s_ready_o(s_axis_tready),
    .q_push_o (q_push),
    .q_item_o (front_item)
  );

  i2crm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (front_item),
    .pop_i  (q_pop),
    .full_o (q_full),
    .valid_o(q_valid),
    .item_o (q_item)
  );

  i2crm_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .q_valid_i(q_valid),
    .q_item_i (q_item),
    .q_pop_o  (q_pop),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .m_res_o  (res)
  );

  assign m_axis_tdata = {2'b00, res.acks_ok, res.done_res, res.busy_res,
                         res.read_valid, res.read_byte, res.sda_level, res.scl_level};

endmodule
